>>> src/rls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rls_pkg;

   localparam int CAP_W     = 13;
   localparam int TICK_W    = 16;
   localparam int ADDR_W    = 12;
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int RSP_W     = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET     = 13'd4096;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd3000;
   localparam logic [LEN_W-1:0]  LEN_MAX       = 3'd7;
   localparam logic [LEN_W-1:0]  ERR_LEN       = 3'd6;
   localparam logic [LEN_W-1:0]  OK_LEN        = 3'd2;

   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_O     = 8'h6F;
   localparam logic [BYTE_W-1:0] CH_K     = 8'h6B;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_RUN     = 3'd0,
      ST_OK      = 3'd1,
      ST_PERR    = 3'd2,
      ST_OVF     = 3'd3,
      ST_TIMEOUT = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY = 1'd0,
      CSR_TIMEOUT  = 1'd1
   } csr_index_type;

   typedef struct packed {
      status_type              status;
      logic                    done_res;
      logic [BYTE_W-1:0]       char_value;
      logic [ADDR_W-1:0]       char_addr;
      logic                    char_write;
      logic                    sep_write;
   } result_type;

   function automatic logic [BYTE_W-1:0] err_char(input logic [LEN_W-1:0] pos);
      logic [BYTE_W-1:0] c;
      case (pos)
         3'd0:    c = 8'h45;
         3'd1:    c = 8'h72;
         3'd2:    c = 8'h72;
         3'd3:    c = 8'h6F;
         3'd4:    c = 8'h72;
         3'd5:    c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> src/rls_core.sv
`timescale 1ns / 1ps
`default_nettype none
module rls_core
   import rls_pkg::*;
#(
   parameter int MAX_BUFFER = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire op_type            op,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire logic [CAP_W-1:0]  capacity,
   input  wire logic [TICK_W-1:0] timeout_ticks,
   output result_type             result
);

   localparam int CNT_W = $clog2(MAX_BUFFER + 1);
   localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BUFFER);

   logic [CNT_W-1:0]  used_ff, used_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              err_ff, err_in;
   logic              ok_ff, ok_in;
   logic              blank_ff, blank_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic              active_ff, active_in;

   logic [CMP_W-1:0]  cap;
   logic [CMP_W-1:0]  need_end;
   logic              need_sep;
   logic [CNT_W-1:0]  used_sep;
   logic [BYTE_W-1:0] val;
   logic [TICK_W-1:0] ticks_inc;
   logic              is_eol;

   always_comb begin
      cap      = (CMP_W'(capacity) > MAX_CMP) ? MAX_CMP : CMP_W'(capacity);
      need_sep = (len_ff == '0) && (used_ff != '0);
      need_end = CMP_W'(used_ff) + (need_sep ? CMP_W'(2) : CMP_W'(1));
      used_sep = used_ff + CNT_W'(need_sep);
      val      = (rx_byte == '0) ? CH_QUERY : rx_byte;
      is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
      ticks_inc = (ticks_ff == '1) ? ticks_ff : ticks_ff + TICK_W'(1);
   end

   always_comb begin
      used_in   = used_ff;
      len_in    = len_ff;
      err_in    = err_ff;
      ok_in     = ok_ff;
      blank_in  = blank_ff;
      ticks_in  = ticks_ff;
      active_in = active_ff;
      result    = '0;
      result.status = ST_RUN;
      case (op)
         OP_START: begin
            used_in   = '0;
            ticks_in  = '0;
            len_in    = '0;
            err_in    = 1'b1;
            ok_in     = 1'b1;
            blank_in  = 1'b0;
            active_in = 1'b1;
         end
         OP_BYTE: begin
            if (active_ff) begin
               if (is_eol) begin
                  if (len_ff != '0) begin
                     if (err_ff && len_ff >= ERR_LEN) begin
                        result.done_res = 1'b1;
                        result.status   = ST_PERR;
                     end else if (ok_ff && len_ff >= OK_LEN
                                  && (len_ff == OK_LEN || blank_ff)) begin
                        result.done_res = 1'b1;
                        result.status   = ST_OK;
                     end else begin
                        len_in   = '0;
                        err_in   = 1'b1;
                        ok_in    = 1'b1;
                        blank_in = 1'b0;
                     end
                  end
               end else if (need_end >= cap) begin
                  result.done_res = 1'b1;
                  result.status   = ST_OVF;
               end else begin
                  result.sep_write  = need_sep;
                  result.char_write = 1'b1;
                  result.char_addr  = ADDR_W'(used_sep);
                  result.char_value = val;
                  used_in = used_sep + CNT_W'(1);
                  if (len_ff < ERR_LEN && val != err_char(len_ff)) begin
                     err_in = 1'b0;
                  end
                  if (len_ff == 3'd0 && val != CH_O) begin
                     ok_in = 1'b0;
                  end
                  if (len_ff == 3'd1 && val != CH_K) begin
                     ok_in = 1'b0;
                  end
                  if (len_ff == 3'd2) begin
                     blank_in = (val == CH_SPACE) || (val == CH_TAB);
                  end
                  if (len_ff < LEN_MAX) begin
                     len_in = len_ff + LEN_W'(1);
                  end
               end
            end
         end
         OP_TICK: begin
            if (active_ff) begin
               ticks_in = ticks_inc;
               if (ticks_inc >= timeout_ticks) begin
                  result.done_res = 1'b1;
                  result.status   = ST_TIMEOUT;
               end
            end
         end
         default: begin
         end
      endcase
      if (result.done_res) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         len_ff    <= '0;
         err_ff    <= 1'b1;
         ok_ff     <= 1'b1;
         blank_ff  <= 1'b0;
         ticks_ff  <= '0;
         active_ff <= 1'b0;
      end else if (step) begin
         used_ff   <= used_in;
         len_ff    <= len_in;
         err_ff    <= err_in;
         ok_ff     <= ok_in;
         blank_ff  <= blank_in;
         ticks_ff  <= ticks_in;
         active_ff <= active_in;
      end
   end

endmodule
`default_nettype wire

>>> src/printer_reply_line_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// Printer reply line scanner.
// req_ channel carries one item per transaction: req_tuser is the op
// (start, received byte, tick) and req_tdata the received byte.
// rsp_ channel returns exactly one result per item, in order, packed in
// rsp_tdata: buffer write strobes, address and character, done flag and
// final status.
// csr_ channel writes response_capacity (index 0) and timeout_ticks
// (index 1); write only while no item is in flight.
// An accepted item enters the input register and is processed, in a single
// pass that decodes it and updates the scan state, once the result register
// is free; its result then enters the result register. Throughput: one item
// per cycle unless a low rsp_tready stalls the output.
// Reset empties both registers (clears their valid flags), sets the scan
// state idle and sets the CSR registers to capacity 4096 and timeout 3000.
// When rsp_tready is low the result register holds, the input register
// keeps one more item, and req_tready drops once both are full.
module printer_reply_line_scanner
   import rls_pkg::*;
#(
   parameter int MAX_BUFFER = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [BYTE_W-1:0]    req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]           req_tuser,   // [1:0] op
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // [0] sep_write, [1] char_write, [13:2] char_addr, [21:14] char_value,
   // [22] done_res, [25:23] status, [31:26] zero
   output logic [RSP_W-1:0]          rsp_tdata,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   logic              in_valid_ff;
   op_type            op_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [TICK_W-1:0] timeout_ff;
   logic              out_free;
   logic              step;
   result_type        result;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - $bits(result_type)){1'b0}}, rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff   <= op_type'(req_tuser);
         byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CAP_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAPACITY: cap_ff     <= csr_data[CAP_W-1:0];
            CSR_TIMEOUT:  timeout_ff <= csr_data[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rls_core #(
      .MAX_BUFFER(MAX_BUFFER)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step(step),
      .op(op_ff),
      .rx_byte(byte_ff),
      .capacity(cap_ff),
      .timeout_ticks(timeout_ff),
      .result(result)
   );

`ifndef SYNTHESIS
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.done_res == (rsp_ff.status != ST_RUN)))
      else $error("done flag and status disagree");

   a_sep_with_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.sep_write) |-> (rsp_ff.char_write && !rsp_ff.done_res))
      else $error("separator write without character write");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed item lost");
`endif

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
   import rls_pkg::*;

   localparam logic [1:0]       OP_UNUSED   = 2'd3;
   localparam logic [CAP_W-1:0] BUF_LIMIT   = 13'd4096;
   localparam logic [47:0]      ERROR_TAG   = "Error:";
   localparam int               QUIET_LIMIT = 5000;
   localparam int               SEG_ITEMS   = 80;
   localparam result_type       NO_EFFECT   = '0;

   typedef struct {
      bit                limits;
      logic [1:0]        op;
      logic [BYTE_W-1:0] data;
      logic [15:0]       cap_word;
      logic [15:0]       tmo_word;
      bit                typed;
      result_type        want;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata = '0;
   logic [1:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   bit         note_typed = 1'b0;
   result_type note_want = '0;

   // scanner state as predicted
   logic [CAP_W-1:0]  cap_limit;
   logic [TICK_W-1:0] tick_limit;
   logic [CAP_W-1:0]  stored_count;
   logic [LEN_W-1:0]  line_fill;
   bit                error_tag_alive;
   bit                ok_tag_alive;
   bit                blank_after_ok;
   logic [TICK_W-1:0] tick_count;
   bit                scan_open;

   result_type     reply_q[$];
   script_row_type script_q[$];
   int         send_gap = 0;
   int         take_gap = 0;
   int         live_items = 0;
   int         replies_checked = 0;
   int         limit_sets = 0;
   int         fail_count = 0;
   int         quiet_cycles = 0;
   int         endings[5] = '{default: 0};

   printer_reply_line_scanner uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   task automatic new_line();
      line_fill = '0;
      error_tag_alive = 1'b1;
      ok_tag_alive = 1'b1;
      blank_after_ok = 1'b0;
   endtask

   task automatic predict_reply(input logic [1:0] op, input logic [BYTE_W-1:0] b,
                                output result_type r);
      logic [CAP_W-1:0]  lim;
      logic [CAP_W-1:0]  room;
      logic [1:0]        need;
      logic [BYTE_W-1:0] v;
      r = NO_EFFECT;
      case (op)
         OP_START: begin
            stored_count = '0;
            tick_count = '0;
            new_line();
            scan_open = 1'b1;
         end
         OP_BYTE: begin
            if (scan_open) begin
               if (b == CH_CR || b == CH_LF) begin
                  if (line_fill != 0) begin
                     if (error_tag_alive && line_fill >= ERR_LEN) begin
                        r.done_res = 1'b1;
                        r.status = ST_PERR;
                     end else if (ok_tag_alive && line_fill >= OK_LEN &&
                                  (line_fill == OK_LEN || blank_after_ok)) begin
                        r.done_res = 1'b1;
                        r.status = ST_OK;
                     end else begin
                        new_line();
                     end
                  end
               end else begin
                  lim = (cap_limit > BUF_LIMIT) ? BUF_LIMIT : cap_limit;
                  room = (lim > stored_count) ? lim - stored_count : '0;
                  need = (line_fill == 0 && stored_count != 0) ? 2'd2 : 2'd1;
                  if (need >= room) begin
                     r.done_res = 1'b1;
                     r.status = ST_OVF;
                  end else begin
                     if (need == 2'd2) begin
                        r.sep_write = 1'b1;
                        stored_count++;
                     end
                     v = (b == 8'h00) ? CH_QUERY : b;
                     r.char_write = 1'b1;
                     r.char_addr = stored_count[ADDR_W-1:0];
                     r.char_value = v;
                     stored_count++;
                     if (line_fill < ERR_LEN &&
                         v != ERROR_TAG[8 * (5 - int'(line_fill)) +: 8])
                        error_tag_alive = 1'b0;
                     if (line_fill == 0 && v != CH_O)
                        ok_tag_alive = 1'b0;
                     if (line_fill == 1 && v != CH_K)
                        ok_tag_alive = 1'b0;
                     if (line_fill == 2)
                        blank_after_ok = (v == CH_SPACE || v == CH_TAB);
                     if (line_fill != LEN_MAX)
                        line_fill++;
                  end
               end
            end
         end
         OP_TICK: begin
            if (scan_open) begin
               if (tick_count != 16'hFFFF)
                  tick_count++;
               if (tick_count >= tick_limit) begin
                  r.done_res = 1'b1;
                  r.status = ST_TIMEOUT;
               end
            end
         end
         default: ;
      endcase
      if (r.done_res)
         scan_open = 1'b0;
   endtask

   task automatic report_field(input string name, input logic [15:0] w, input logic [15:0] g);
      if (w !== g) begin
         $error("%s: expected %0d, got %0d", name, w, g);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      if (reset) begin
         cap_limit = CAP_RESET;
         tick_limit = TIMEOUT_RESET;
         stored_count = '0;
         tick_count = '0;
         new_line();
         scan_open = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAPACITY: cap_limit = csr_data[CAP_W-1:0];
               CSR_TIMEOUT:  tick_limit = csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_START || scan_open)
               live_items++;
            predict_reply(req_tuser, req_tdata, want);
            reply_q.push_back(note_typed ? note_want : want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[25:0]);
            if (reply_q.size() == 0) begin
               $error("result with no expectation pending: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = reply_q.pop_front();
               replies_checked++;
               report_field("sep_write", 16'(want.sep_write), 16'(got.sep_write));
               report_field("char_write", 16'(want.char_write), 16'(got.char_write));
               report_field("char_addr", 16'(want.char_addr), 16'(got.char_addr));
               report_field("char_value", 16'(want.char_value), 16'(got.char_value));
               report_field("done_res", 16'(want.done_res), 16'(got.done_res));
               report_field("status", 16'(want.status), 16'(got.status));
               if (want.done_res && int'(want.status) < 5)
                  endings[int'(want.status)]++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= take_gap);
   end

   task automatic send_item(input logic [1:0] op, input logic [BYTE_W-1:0] b,
                            input bit typed = 1'b0, input result_type want = '0);
      while ($urandom_range(99) < send_gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= b;
      note_typed <= typed;
      note_want <= want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (reply_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_limits(input logic [15:0] cap_word, input logic [15:0] tmo_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_CAPACITY;
      csr_data <= cap_word;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_data <= tmo_word;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      limit_sets++;
   endtask

   task automatic row_item(input logic [1:0] op, input logic [BYTE_W-1:0] b);
      script_row_type s;
      s = '{limits: 1'b0, op: op, data: b, cap_word: '0, tmo_word: '0,
            typed: 1'b0, want: NO_EFFECT};
      script_q.push_back(s);
   endtask

   task automatic row_want(input logic [1:0] op, input logic [BYTE_W-1:0] b,
                           input result_type want);
      script_row_type s;
      s = '{limits: 1'b0, op: op, data: b, cap_word: '0, tmo_word: '0,
            typed: 1'b1, want: want};
      script_q.push_back(s);
   endtask

   task automatic row_limits(input logic [15:0] cap_word, input logic [15:0] tmo_word);
      script_row_type s;
      s = '{limits: 1'b1, op: '0, data: '0, cap_word: cap_word, tmo_word: tmo_word,
            typed: 1'b0, want: NO_EFFECT};
      script_q.push_back(s);
   endtask

   function automatic result_type char_put(input bit sep, input logic [ADDR_W-1:0] a,
                                           input logic [BYTE_W-1:0] v);
      result_type r;
      r = NO_EFFECT;
      r.sep_write = sep;
      r.char_write = 1'b1;
      r.char_addr = a;
      r.char_value = v;
      return r;
   endfunction

   function automatic result_type finish_with(input status_type s);
      result_type r;
      r = NO_EFFECT;
      r.done_res = 1'b1;
      r.status = s;
      return r;
   endfunction

   task automatic send_text(input int n);
      logic [BYTE_W-1:0] b;
      repeat (n) begin
         if ($urandom_range(9) == 0)
            send_item(OP_TICK, BYTE_W'($urandom_range(255)));
         b = BYTE_W'($urandom_range(255));
         if (b == CH_CR || b == CH_LF || $urandom_range(9) == 0)
            b = 8'h00;
         send_item(OP_BYTE, b);
      end
   endtask

   task automatic send_line();
      int k;
      case ($urandom_range(9))
         0, 1: begin
            send_item(OP_BYTE, CH_O);
            send_item(OP_BYTE, CH_K);
            case ($urandom_range(3))
               0: ;
               1: send_item(OP_BYTE, CH_SPACE);
               2: send_item(OP_BYTE, CH_TAB);
               default: send_text($urandom_range(1, 3));
            endcase
            if ($urandom_range(3) == 0)
               send_text($urandom_range(1, 3));
         end
         2, 3: begin
            k = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 6;
            for (int i = 0; i < k; i++)
               send_item(OP_BYTE, ERROR_TAG[8 * (5 - i) +: 8]);
            send_text($urandom_range(0, 4));
         end
         4: ;
         5: begin
            send_item(OP_BYTE, CH_O);
            send_text($urandom_range(1, 4));
         end
         default: send_text($urandom_range(1, 12));
      endcase
      send_item(OP_BYTE, $urandom_range(1) ? CH_CR : CH_LF);
      if ($urandom_range(5) == 0)
         send_item(OP_BYTE, CH_LF);
   endtask

   task automatic send_transaction();
      int lines;
      lines = $urandom_range(1, 8);
      send_item(OP_START, BYTE_W'($urandom_range(255)));
      while (scan_open && lines > 0) begin
         if ($urandom_range(5) == 0)
            repeat ($urandom_range(1, 20)) send_item(OP_TICK, BYTE_W'($urandom_range(255)));
         else
            send_line();
         lines--;
      end
      if (!scan_open && $urandom_range(3) == 0)
         repeat ($urandom_range(1, 3))
            send_item(2'($urandom_range(3)), BYTE_W'($urandom_range(255)));
   endtask

   initial begin
      logic [15:0] cap_word;
      logic [15:0] tmo_word;
      int          target;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      row_want(OP_BYTE, "A", NO_EFFECT);
      row_want(OP_TICK, 8'hFF, NO_EFFECT);
      row_want(OP_UNUSED, 8'hFF, NO_EFFECT);
      row_want(OP_START, 8'h00, NO_EFFECT);
      row_want(OP_BYTE, CH_CR, NO_EFFECT);
      row_want(OP_BYTE, CH_O, char_put(1'b0, 12'd0, CH_O));
      row_want(OP_BYTE, CH_K, char_put(1'b0, 12'd1, CH_K));
      row_want(OP_START, 8'h00, NO_EFFECT);
      row_item(OP_BYTE, CH_O);
      row_item(OP_BYTE, CH_K);
      row_item(OP_BYTE, CH_TAB);
      row_want(OP_BYTE, CH_LF, finish_with(ST_OK));
      row_want(OP_START, 8'h00, NO_EFFECT);
      row_want(OP_BYTE, 8'h00, char_put(1'b0, 12'd0, CH_QUERY));
      row_want(OP_BYTE, CH_CR, NO_EFFECT);
      row_want(OP_BYTE, "E", char_put(1'b1, 12'd2, "E"));
      row_item(OP_BYTE, "r");
      row_item(OP_BYTE, "r");
      row_item(OP_BYTE, "o");
      row_item(OP_BYTE, "r");
      row_item(OP_BYTE, ":");
      row_want(OP_BYTE, CH_LF, finish_with(ST_PERR));
      row_limits(16'hE003, 16'h0000);
      row_want(OP_START, 8'h00, NO_EFFECT);
      row_want(OP_TICK, 8'h00, finish_with(ST_TIMEOUT));
      row_want(OP_START, 8'h00, NO_EFFECT);
      row_want(OP_BYTE, "a", char_put(1'b0, 12'd0, "a"));
      row_want(OP_BYTE, 8'hFF, char_put(1'b0, 12'd1, 8'hFF));
      row_want(OP_BYTE, "c", finish_with(ST_OVF));

      foreach (script_q[i]) begin
         if (script_q[i].limits) begin
            settle();
            set_limits(script_q[i].cap_word, script_q[i].tmo_word);
         end else begin
            send_item(script_q[i].op, script_q[i].data, script_q[i].typed, script_q[i].want);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_gap = (phase == 0) ? 38 : (phase == 1) ? 66 : 0;
         take_gap = (phase == 0) ? 66 : (phase == 1) ? 38 : 0;
         for (int seg = 0; seg < 5; seg++) begin
            cap_word = 16'($urandom);
            tmo_word = 16'($urandom);
            if (seg == 0) begin
               cap_word = 16'hFFFF;
               tmo_word = 16'hFFFF;
            end else if (seg == 1) begin
               cap_word[CAP_W-1:0] = 13'd1;
               tmo_word = 16'd1;
            end else begin
               case ($urandom_range(7))
                  0: cap_word[CAP_W-1:0] = 13'd0;
                  1: cap_word[CAP_W-1:0] = 13'd2;
                  2: cap_word[CAP_W-1:0] = BUF_LIMIT;
                  3: cap_word[CAP_W-1:0] = 13'd4095;
                  default: cap_word[CAP_W-1:0] = CAP_W'($urandom_range(3, 40));
               endcase
               case ($urandom_range(5))
                  0: tmo_word = 16'd0;
                  1: tmo_word = TIMEOUT_RESET;
                  2: tmo_word = 16'hFFFF;
                  default: tmo_word = 16'($urandom_range(2, 30));
               endcase
            end
            settle();
            set_limits(cap_word, tmo_word);
            target = live_items + SEG_ITEMS;
            while (live_items < target)
               send_transaction();
         end
      end

      settle();
      repeat (4) @(negedge clock);
      $display("Checked %0d replies for %0d live items over %0d limit settings",
               replies_checked, live_items, limit_sets);
      $display("Endings: ok %0d, printer error %0d, overflow %0d, timeout %0d",
               endings[ST_OK], endings[ST_PERR], endings[ST_OVF], endings[ST_TIMEOUT]);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> filelist.f
src/rls_pkg.sv
src/rls_core.sv
src/printer_reply_line_scanner.sv
bench/tb.sv
